// ----- sv/skvl_pkg.sv -----
// skvl_pkg: shared types and codes for the sorted key/value leaf table
// used by skvl_cell, sorted_key_value_leaf_table and skvl_checker
`timescale 1ns / 1ps

package skvl_pkg;

  localparam int ENTRIES_DEF     = 64;
  localparam int KEY_WIDTH_DEF   = 32;
  localparam int VALUE_WIDTH_DEF = 64;

  localparam int OP_W     = 2;
  localparam int STATUS_W = 3;
  localparam int FIELD7_W = 7;

  localparam logic [FIELD7_W-1:0] CAP_RESET = 7'd64;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_FOUND     = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_REMOVED   = 3'd5;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_EXE
  } state_t;

  // control broadcast to every cell of the row
  typedef struct packed {
    logic cmp;   // capture compare flags
    logic ins;   // open a slot at the boundary and write the new pair
    logic rem;   // close the slot at the boundary
  } cell_ctl_t;

endpackage

// ----- sv/skvl_cell.sv -----
// skvl_cell: one slot of the sorted row, holds a key/value pair and its compare flags
// depends on skvl_pkg; neighbors are wired by sorted_key_value_leaf_table
`timescale 1ns / 1ps

module skvl_cell #(
  parameter int KEY_WIDTH   = skvl_pkg::KEY_WIDTH_DEF,
  parameter int VALUE_WIDTH = skvl_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  skvl_pkg::cell_ctl_t    ctl,
  input  logic                   occupied,
  input  logic                   lt_left,
  input  logic [KEY_WIDTH-1:0]   search_key,
  input  logic [VALUE_WIDTH-1:0] row_value,
  input  logic [KEY_WIDTH-1:0]   left_key,
  input  logic [VALUE_WIDTH-1:0] left_value,
  input  logic [KEY_WIDTH-1:0]   right_key,
  input  logic [VALUE_WIDTH-1:0] right_value,
  output logic [KEY_WIDTH-1:0]   key,
  output logic [VALUE_WIDTH-1:0] value,
  output logic                   lt,
  output logic                   eq
);
  import skvl_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      lt <= occupied && (key < search_key);
      eq <= occupied && (key == search_key);
    end
    // cells below the boundary keep their pair
    if (ctl.ins && !lt) begin
      if (lt_left) begin
        key   <= search_key;
        value <= row_value;
      end else begin
        key   <= left_key;
        value <= left_value;
      end
    end else if (ctl.rem && !lt) begin
      key   <= right_key;
      value <= right_value;
    end
  end

endmodule

// ----- sv/sorted_key_value_leaf_table.sv -----
// sorted_key_value_leaf_table: accepts one item at a time, a new one only after the last
// has left S_EXE: capture, compare in every cell, then resolve and shift the whole cell
// row in one step; a result waiting on m_tready holds the row
// reset clears the entry count and any pending result and sets capacity_limit to 64;
// key and value slots are not cleared, only slots below the count are ever read
`timescale 1ns / 1ps

module sorted_key_value_leaf_table #(
  parameter int ENTRIES     = skvl_pkg::ENTRIES_DEF,
  parameter int KEY_WIDTH   = skvl_pkg::KEY_WIDTH_DEF,
  parameter int VALUE_WIDTH = skvl_pkg::VALUE_WIDTH_DEF,
  localparam int S_DW = ((KEY_WIDTH + VALUE_WIDTH + 7) / 8) * 8,
  localparam int M_DW = ((VALUE_WIDTH + 2 * skvl_pkg::FIELD7_W + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [skvl_pkg::FIELD7_W-1:0] cfg_wr_data,   // capacity_limit
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [S_DW-1:0]               s_tdata,       // search_key, row_value
  input  logic [skvl_pkg::OP_W-1:0]     s_tuser,       // op
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [M_DW-1:0]               m_tdata,       // found_value, entry_count, position
  output logic [skvl_pkg::STATUS_W-1:0] m_tuser        // status
);
  import skvl_pkg::*;

  localparam int CW = $clog2(ENTRIES + 1);
  localparam int LW = (CW > FIELD7_W) ? CW : FIELD7_W;

  state_t state, state_next;
  cell_ctl_t ctl;

  logic [OP_W-1:0]        op_q;
  logic [KEY_WIDTH-1:0]   key_q;
  logic [VALUE_WIDTH-1:0] val_q;
  logic [CW-1:0]          count, count_next;
  logic [FIELD7_W-1:0]    cap_limit;

  logic [KEY_WIDTH-1:0]   cell_key [ENTRIES];
  logic [VALUE_WIDTH-1:0] cell_val [ENTRIES];
  logic [ENTRIES-1:0]     lt_vec;
  logic [ENTRIES-1:0]     eq_vec;
  logic [ENTRIES:0]       boundary;

  logic [CW-1:0]          pos;
  logic                   hit;
  logic [VALUE_WIDTH-1:0] hit_value;
  logic [LW-1:0]          eff_limit;
  logic                   full;
  logic                   exe_fire;
  logic                   do_ins, do_rem;
  logic [STATUS_W-1:0]    status;
  logic [VALUE_WIDTH-1:0] found_value;

  logic [VALUE_WIDTH-1:0] found_q;
  logic [FIELD7_W-1:0]    cnt_q, pos_q;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic                   lt_left;
    logic [KEY_WIDTH-1:0]   left_key, right_key;
    logic [VALUE_WIDTH-1:0] left_val, right_val;

    if (i == 0) begin : g_first
      assign lt_left  = 1'b1;
      assign left_key = key_q;
      assign left_val = val_q;
    end else begin : g_mid
      assign lt_left  = lt_vec[i-1];
      assign left_key = cell_key[i-1];
      assign left_val = cell_val[i-1];
    end

    if (i == ENTRIES - 1) begin : g_last
      assign right_key = cell_key[i];
      assign right_val = cell_val[i];
    end else begin : g_inner
      assign right_key = cell_key[i+1];
      assign right_val = cell_val[i+1];
    end

    skvl_cell #(
      .KEY_WIDTH   (KEY_WIDTH),
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occupied    (CW'(i) < count),
      .lt_left     (lt_left),
      .search_key  (key_q),
      .row_value   (val_q),
      .left_key    (left_key),
      .left_value  (left_val),
      .right_key   (right_key),
      .right_value (right_val),
      .key         (cell_key[i]),
      .value       (cell_val[i]),
      .lt          (lt_vec[i]),
      .eq          (eq_vec[i])
    );

    assign boundary[i] = !lt_vec[i] && lt_left;
  end

  assign boundary[ENTRIES] = lt_vec[ENTRIES-1];

  // boundary is one-hot, so position and hit value are plain or-trees
  always_comb begin
    pos       = '0;
    hit_value = '0;
    for (int i = 0; i <= ENTRIES; i++) begin
      if (boundary[i]) pos = pos | CW'(i);
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (boundary[i] && eq_vec[i]) hit_value = hit_value | cell_val[i];
    end
  end

  assign hit       = |(boundary[ENTRIES-1:0] & eq_vec);
  assign eff_limit = (LW'(cap_limit) > LW'(ENTRIES)) ? LW'(ENTRIES) : LW'(cap_limit);
  assign full      = LW'(count) >= eff_limit;

  always_comb begin
    status      = STAT_NOT_FOUND;
    found_value = '0;
    do_ins      = 1'b0;
    do_rem      = 1'b0;
    unique case (op_q)
      OP_INSERT: begin
        if (hit) status = STAT_DUPLICATE;
        else if (full) status = STAT_FULL;
        else begin
          status = STAT_INSERTED;
          do_ins = 1'b1;
        end
      end
      OP_LOOKUP: begin
        if (hit) begin
          status      = STAT_FOUND;
          found_value = hit_value;
        end
      end
      OP_REMOVE: begin
        if (hit) begin
          status = STAT_REMOVED;
          do_rem = 1'b1;
        end
      end
      default: status = STAT_NOT_FOUND;
    endcase
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    exe_fire   = 1'b0;
    ctl        = '0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = S_CMP;
      end
      S_CMP: begin
        ctl.cmp    = 1'b1;
        state_next = S_EXE;
      end
      S_EXE: begin
        // hold the row while the previous result is still waiting
        if (!m_tvalid || m_tready) begin
          exe_fire   = 1'b1;
          ctl.ins    = do_ins;
          ctl.rem    = do_rem;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    count_next = count;
    if (ctl.ins) count_next = count + 1'b1;
    else if (ctl.rem) count_next = count - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      cap_limit <= CAP_RESET;
      m_tvalid  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (cfg_wr_en) cap_limit <= cfg_wr_data;
      if (exe_fire) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op_q  <= s_tuser;
      key_q <= s_tdata[KEY_WIDTH-1:0];
      val_q <= s_tdata[KEY_WIDTH+VALUE_WIDTH-1:KEY_WIDTH];
    end
    if (exe_fire) begin
      m_tuser <= status;
      found_q <= found_value;
      cnt_q   <= FIELD7_W'(count_next);
      pos_q   <= FIELD7_W'(pos);
    end
  end

  assign m_tdata = M_DW'({pos_q, cnt_q, found_q});

endmodule

// ----- sv/skvl_checker.sv -----
// skvl_checker: port-level checks for sorted_key_value_leaf_table
// depends on skvl_pkg; attached to the top level by the bind below
`timescale 1ns / 1ps

module skvl_checker #(
  parameter int ENTRIES     = skvl_pkg::ENTRIES_DEF,
  parameter int KEY_WIDTH   = skvl_pkg::KEY_WIDTH_DEF,
  parameter int VALUE_WIDTH = skvl_pkg::VALUE_WIDTH_DEF,
  localparam int S_DW = ((KEY_WIDTH + VALUE_WIDTH + 7) / 8) * 8,
  localparam int M_DW = ((VALUE_WIDTH + 2 * skvl_pkg::FIELD7_W + 7) / 8) * 8
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [M_DW-1:0]               m_tdata,
  input logic [skvl_pkg::STATUS_W-1:0] m_tuser
);
  import skvl_pkg::*;

  // a waiting result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // one item in flight: no new item right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("item accepted while previous still in flight");

  // value field is zero unless a lookup hit
  a_found_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != STAT_FOUND) |-> m_tdata[VALUE_WIDTH-1:0] == '0)
    else $error("found_value nonzero without a hit");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind sorted_key_value_leaf_table skvl_checker #(
  .ENTRIES     (ENTRIES),
  .KEY_WIDTH   (KEY_WIDTH),
  .VALUE_WIDTH (VALUE_WIDTH)
) u_skvl_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ----- tb/sv/tb_sorted_key_value_leaf_table.sv -----
// tb_sorted_key_value_leaf_table: self-checking bench for the sorted key/value leaf table
// a shadow table predicts every reply; depends on skvl_pkg and sorted_key_value_leaf_table
`timescale 1ns / 1ps

module tb_sorted_key_value_leaf_table;
  import skvl_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int ROWS        = ENTRIES_DEF;
  localparam int S_DW        = ((KEY_WIDTH_DEF + VALUE_WIDTH_DEF + 7) / 8) * 8;
  localparam int M_DW        = ((VALUE_WIDTH_DEF + 2 * FIELD7_W + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int POOL_SIZE   = 80;

  typedef struct packed {
    logic [STATUS_W-1:0]        status;
    logic [VALUE_WIDTH_DEF-1:0] found;
    logic [FIELD7_W-1:0]        entries;
    logic [FIELD7_W-1:0]        pos;
  } leaf_reply_t;

  // shadow copy of the sorted table plus the replies still owed by the block
  class leaf_table_shadow;
    logic [KEY_WIDTH_DEF-1:0]   keys[ROWS];
    logic [VALUE_WIDTH_DEF-1:0] vals[ROWS];
    int unsigned                held;
    logic [FIELD7_W-1:0]        cap;
    leaf_reply_t                expected_replies[$];
    int unsigned                errors;

    function new();
      held = 0;
      cap = CAP_RESET;
      errors = 0;
    endfunction

    function void set_capacity(logic [FIELD7_W-1:0] v);
      cap = v;
    endfunction

    function int unsigned outstanding();
      return expected_replies.size();
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [KEY_WIDTH_DEF-1:0] key,
                               logic [VALUE_WIDTH_DEF-1:0] val);
      int unsigned pos;
      int unsigned limit;
      bit hit;
      leaf_reply_t r;
      pos = 0;
      while (pos < held && keys[pos] < key) pos++;
      hit = (pos < held) && (keys[pos] == key);
      limit = (cap > ROWS) ? ROWS : cap;
      r.status = STAT_NOT_FOUND;
      r.found = '0;
      case (op)
        OP_INSERT: begin
          if (hit) begin
            r.status = STAT_DUPLICATE;
          end else if (held >= limit) begin
            r.status = STAT_FULL;
          end else begin
            for (int i = held; i > pos; i--) begin
              keys[i] = keys[i-1];
              vals[i] = vals[i-1];
            end
            keys[pos] = key;
            vals[pos] = val;
            held++;
            r.status = STAT_INSERTED;
          end
        end
        OP_LOOKUP: begin
          if (hit) begin
            r.status = STAT_FOUND;
            r.found = vals[pos];
          end
        end
        OP_REMOVE: begin
          if (hit) begin
            for (int i = pos; i + 1 < held; i++) begin
              keys[i] = keys[i+1];
              vals[i] = vals[i+1];
            end
            held--;
            r.status = STAT_REMOVED;
          end
        end
        default: ;
      endcase
      r.entries = 7'(held);
      r.pos = 7'(pos);
      expected_replies.push_back(r);
    endfunction

    function void check_result(leaf_reply_t got);
      leaf_reply_t exp;
      if (expected_replies.size() == 0) begin
        $error("reply with no request waiting: status %0d", got.status);
        errors++;
        return;
      end
      exp = expected_replies.pop_front();
      if (got.status !== exp.status) begin
        $error("status: expected %0d, actual %0d", exp.status, got.status);
        errors++;
      end
      if (got.found !== exp.found) begin
        $error("found_value: expected %h, actual %h", exp.found, got.found);
        errors++;
      end
      if (got.entries !== exp.entries) begin
        $error("entry_count: expected %0d, actual %0d", exp.entries, got.entries);
        errors++;
      end
      if (got.pos !== exp.pos) begin
        $error("position: expected %0d, actual %0d", exp.pos, got.pos);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [FIELD7_W-1:0]   cfg_wr_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_DW-1:0]       s_tdata = '0;    // search_key, row_value
  logic [OP_W-1:0]       s_tuser = '0;    // op
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_DW-1:0]       m_tdata;         // found_value, entry_count, position
  logic [STATUS_W-1:0]   m_tuser;         // status

  leaf_table_shadow      shadow = new();
  bit                    hold_request = 1'b0;
  int unsigned           cycles = 0;
  logic [KEY_WIDTH_DEF-1:0] key_pool[POOL_SIZE];

  sorted_key_value_leaf_table u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // replies are checked before the request of the same edge is noted
  always @(posedge clk) begin
    leaf_reply_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.status  = m_tuser;
      got.found   = m_tdata[VALUE_WIDTH_DEF-1:0];
      got.entries = m_tdata[VALUE_WIDTH_DEF +: FIELD7_W];
      got.pos     = m_tdata[VALUE_WIDTH_DEF + FIELD7_W +: FIELD7_W];
      shadow.check_result(got);
    end
    if (!rst && s_tvalid && s_tready)
      shadow.note_request(s_tuser, s_tdata[KEY_WIDTH_DEF-1:0],
                          s_tdata[KEY_WIDTH_DEF +: VALUE_WIDTH_DEF]);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: stall pattern changes among four random ready modes span by span, plus one long hold-off
  initial begin
    int unsigned mode;
    int unsigned span;
    mode = 0;
    span = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = 64;
        end
        span--;
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 1) == 0);
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the item is taken
  task automatic drive_item(logic [OP_W-1:0] op, logic [KEY_WIDTH_DEF-1:0] key,
                            logic [VALUE_WIDTH_DEF-1:0] val);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= S_DW'({val, key});
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic idle_gap(int unsigned n);
    s_tvalid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // wait for every owed reply, then let the pipeline settle
  task automatic drain();
    s_tvalid <= 1'b0;
    while (shadow.outstanding() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_capacity(logic [FIELD7_W-1:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    shadow.set_capacity(v);
    @(negedge clk);
  endtask

  function automatic logic [KEY_WIDTH_DEF-1:0] pick_key();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return key_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  function automatic logic [VALUE_WIDTH_DEF-1:0] rand_value();
    return {$urandom, $urandom};
  endfunction

  initial begin
    logic [FIELD7_W-1:0] caps[8];
    int unsigned ins_weight;
    int unsigned burst_left;
    int unsigned roll;
    logic [OP_W-1:0] op;

    caps = '{7'd127, 7'd64, 7'd33, 7'd64, 7'd1, 7'd64, 7'd0, 7'd64};
    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = 32'h8000_0000;
    for (int i = 3; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty table, unused op code, extremes of key and value
    drive_item(OP_LOOKUP, '0, '0);
    drive_item(OP_REMOVE, '1, '1);
    drive_item(OP_UNUSED, 32'h1234_5678, '1);
    drive_item(OP_INSERT, '1, '1);
    drive_item(OP_INSERT, '0, '0);
    drive_item(OP_INSERT, 32'h8000_0000, 64'hA5A5_5A5A_F0F0_0F0F);
    drive_item(OP_INSERT, '0, 64'h1);
    drive_item(OP_LOOKUP, '1, '0);
    drive_item(OP_LOOKUP, 32'h8000_0000, '1);
    drive_item(OP_LOOKUP, 32'h5, '0);
    drive_item(OP_UNUSED, '0, '0);
    drive_item(OP_REMOVE, 32'h8000_0000, '0);
    drive_item(OP_REMOVE, 32'h7, '0);
    // table holds two; duplicate is checked before full
    write_capacity(7'd2);
    drive_item(OP_INSERT, 32'h7, rand_value());
    drive_item(OP_INSERT, '0, rand_value());
    write_capacity(7'd0);
    drive_item(OP_INSERT, 32'h9, rand_value());
    // limit lowered below the count keeps the entries
    write_capacity(7'd1);
    drive_item(OP_INSERT, 32'h9, rand_value());
    drive_item(OP_REMOVE, '1, '0);
    drive_item(OP_INSERT, 32'h9, rand_value());
    drive_item(OP_REMOVE, '0, '0);
    drive_item(OP_INSERT, 32'h9, 64'hFFFF_0000_FFFF_0000);
    drive_item(OP_LOOKUP, 32'h9, '0);

    burst_left = 0;
    for (int ph = 0; ph < 8; ph++) begin
      write_capacity(caps[ph]);
      // alternate filling and emptying so the count sweeps its range
      ins_weight = (ph % 2 == 0) ? 75 : 25;
      for (int n = 0; n < 100; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 20);
          if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 8));
        end
        burst_left--;
        if (ph == 1 && n == 20) hold_request = 1'b1;
        roll = $urandom_range(0, 99);
        if (roll < 2) op = OP_UNUSED;
        else if (roll < ins_weight) op = OP_INSERT;
        else if (roll < ins_weight + (100 - ins_weight) / 2) op = OP_REMOVE;
        else op = OP_LOOKUP;
        drive_item(op, pick_key(), rand_value());
      end
    end

    drain();
    repeat (10) @(negedge clk);
    if (shadow.errors == 0 && shadow.outstanding() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
